// ===== hdl/fpba_pkg.sv =====
// Shared types, constants and codes of the fit-policy block allocator.
package fpba_pkg;

    // Fixed widths of the channel payloads and register fields
    localparam int LOAD_IDX_BITS  = 4;
    localparam int SIZE_VAL_BITS  = 16;
    localparam int CFG_IDX_BITS   = 4;
    localparam int CFG_DATA_BITS  = 8;
    localparam int MODE_BITS      = 2;
    localparam int COUNT_BITS     = 5;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    // Reset value of the block count register
    localparam logic [COUNT_BITS-1:0] BLOCKS_RESET = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FIT_MODE      = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCKS_IN_USE = 4'd1;

    // Fit policy codes (code 3 behaves as first fit)
    localparam logic [MODE_BITS-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_WORST = 2'd2;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic latch;         // capture the input transaction
        logic issue;         // read the next table entry
        logic commit_load;   // write loaded size, push load response
        logic commit_alloc;  // write back chosen block, push response
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_end;      // every taking-part entry has been read
        logic out_free;      // output register can take a response
    } t_dp_status;

endpackage

// ===== hdl/fpba_ifs.sv =====
// Channel interfaces: request, response and configuration write.
interface fpba_req_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [fpba_pkg::LOAD_IDX_BITS-1:0] load_index;
    logic [fpba_pkg::SIZE_VAL_BITS-1:0] size_value;

    modport source (output valid, output operation, output load_index,
                    output size_value, input ready);
    modport sink   (input valid, input operation, input load_index,
                    input size_value, output ready);
endinterface

interface fpba_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               granted;
    logic [fpba_pkg::LOAD_IDX_BITS-1:0] chosen_block;
    logic [fpba_pkg::SIZE_VAL_BITS-1:0] space_left;

    modport source (output valid, output granted, output chosen_block,
                    output space_left, input ready);
    modport sink   (input valid, input granted, input chosen_block,
                    input space_left, output ready);
endinterface

interface fpba_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fpba_pkg::CFG_IDX_BITS-1:0]  index;
    logic [fpba_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fit_policy_block_allocator.sv =====
// Top level of the fit-policy block allocator.
//
// Usage:
//   i_req  : request channel. operation 0 loads size_value into block
//            load_index; operation 1 allocates size_value by the policy in
//            fit_mode (first, best or worst fit, ties to the lowest index).
//   o_rsp  : one response per request transaction: granted, chosen_block,
//            space_left. Refused requests and loads respond with all zeros.
//   i_cfg  : register writes (index 0 fit_mode, 1 blocks_in_use); always
//            ready, write only while the block is idle.
// Sequencing: a load passes through S_LOAD and then fills the response register.
//   An allocation reads one table entry per cycle from the size memory in
//   S_SCAN, then S_WB writes the response register.
// Flow: one request at a time; i_req.ready is high only when the
//   controller is idle, so a new transaction can start while the previous
//   response still waits in the output register.
// Reset: all sizes read as zero, fit_mode first fit, blocks_in_use 16.
// Stall: while o_rsp is held, a finished item waits in its final state and
//   the table write-back happens together with the response hand-off.
module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpba_req_if.sink   i_req,
    fpba_rsp_if.source o_rsp,
    fpba_cfg_if.sink   i_cfg
);
    import fpba_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // config registers never back-pressure
    assign i_cfg.ready = 1'b1;

    fpba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_alloc (i_req.operation == OP_ALLOC),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    fpba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load_index   (i_req.load_index),
        .i_size_value   (i_req.size_value),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_granted      (o_rsp.granted),
        .o_chosen_block (o_rsp.chosen_block),
        .o_space_left   (o_rsp.space_left),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule

// ===== hdl/fpba_ctrl.sv =====
// Controller state machine of the allocator: load, scan and write-back sequencing.
module fpba_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_alloc,
    output logic                 o_req_ready,
    input  fpba_pkg::t_dp_status i_status,
    output fpba_pkg::t_dp_cmd    o_cmd
);
    import fpba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = i_req_alloc ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.commit_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SCAN: begin
                // last compare lands on the edge that leaves this state
                if (i_status.scan_end) begin
                    n_state = S_WB;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_WB: begin
                if (i_status.out_free) begin
                    o_cmd.commit_alloc = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fpba_dp.sv =====
// Datapath of the allocator: size table, scan compare, config registers, output register.
module fpba_dp #(
    parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input transaction payload
    input  logic [fpba_pkg::LOAD_IDX_BITS-1:0] i_load_index,
    input  logic [fpba_pkg::SIZE_VAL_BITS-1:0] i_size_value,
    // configuration write
    input  logic                               i_cfg_valid,
    input  logic [fpba_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // response
    input  logic                               i_rsp_ready,
    output logic                               o_rsp_valid,
    output logic                               o_granted,
    output logic [fpba_pkg::LOAD_IDX_BITS-1:0] o_chosen_block,
    output logic [fpba_pkg::SIZE_VAL_BITS-1:0] o_space_left,
    // control
    input  fpba_pkg::t_dp_cmd                  i_cmd,
    output fpba_pkg::t_dp_status               o_status
);
    import fpba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // size table and its cleared-at-reset valid bits
    logic [SIZE_BITS-1:0]  r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_vld;

    // configuration
    logic [MODE_BITS-1:0]  r_fit_mode;
    logic [COUNT_BITS-1:0] r_blocks;

    // captured item
    logic [LOAD_IDX_BITS-1:0] r_lidx;
    logic [SIZE_BITS-1:0]     r_size;
    logic [CNT_W-1:0]         r_count;

    // scan
    logic [CNT_W-1:0]     r_addr;
    logic                 r_cmp_en;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic                 r_found;
    logic [SIZE_BITS-1:0] r_best;
    logic [IDX_W-1:0]     r_pick;

    // output register
    logic                     r_out_vld;
    logic                     r_out_grant;
    logic [LOAD_IDX_BITS-1:0] r_out_idx;
    logic [SIZE_VAL_BITS-1:0] r_out_left;

    logic [31:0]          cnt_in;
    logic [31:0]          cnt_sat;
    logic [31:0]          lidx_ext;
    logic [31:0]          size_ext;
    logic [31:0]          pick_ext;
    logic [31:0]          left_ext;
    logic                 load_ok;
    logic [SIZE_BITS-1:0] rd_value;
    logic                 qual;
    logic                 better;
    logic [SIZE_BITS-1:0] new_left;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    logic [SIZE_BITS-1:0] mem_wd;

    assign cnt_in   = 32'(r_blocks);
    assign cnt_sat  = (cnt_in > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS) : cnt_in;
    assign lidx_ext = 32'(r_lidx);
    assign load_ok  = lidx_ext < 32'(NUM_BLOCKS);
    assign size_ext = 32'(i_size_value);
    assign rd_value = r_rd_vld ? r_rd_data : '0;
    assign new_left = r_best - r_size;
    assign pick_ext = 32'(r_pick);
    assign left_ext = 32'(new_left);

    // an entry qualifies if it holds at least the request
    assign qual   = r_cmp_en && (rd_value >= r_size);
    assign better = !r_found
                  || ((r_fit_mode == MODE_BEST)  && (rd_value < r_best))
                  || ((r_fit_mode == MODE_WORST) && (rd_value > r_best));

    assign o_status.scan_end = (r_addr == r_count);
    assign o_status.out_free = !r_out_vld || i_rsp_ready;

    // table write port: load or write-back
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pick;
        mem_wd = new_left;
        if (i_cmd.commit_load && load_ok) begin
            mem_we = 1'b1;
            mem_wa = lidx_ext[IDX_W-1:0];
            mem_wd = r_size;
        end else if (i_cmd.commit_alloc && r_found) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= MODE_FIRST;
            r_blocks   <= BLOCKS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FIT_MODE:      r_fit_mode <= i_cfg_data[MODE_BITS-1:0];
                REG_BLOCKS_IN_USE: r_blocks   <= i_cfg_data[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // item capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_rd_vld  <= r_vld[r_addr[IDX_W-1:0]];
        r_cmp_idx <= r_addr[IDX_W-1:0];
        if (i_cmd.latch) begin
            r_lidx  <= i_load_index;
            r_size  <= size_ext[SIZE_BITS-1:0];
            r_count <= cnt_sat[CNT_W-1:0];
        end
        if (qual && better) begin
            r_best <= rd_value;
            r_pick <= r_cmp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_cmp_en <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.issue;
            if (i_cmd.latch) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (qual && better) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit_load || i_cmd.commit_alloc) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_load || (i_cmd.commit_alloc && !r_found)) begin
            r_out_grant <= 1'b0;
            r_out_idx   <= '0;
            r_out_left  <= '0;
        end else if (i_cmd.commit_alloc) begin
            r_out_grant <= 1'b1;
            r_out_idx   <= pick_ext[LOAD_IDX_BITS-1:0];
            r_out_left  <= left_ext[SIZE_VAL_BITS-1:0];
        end
    end

    assign o_rsp_valid    = r_out_vld;
    assign o_granted      = r_out_grant;
    assign o_chosen_block = r_out_idx;
    assign o_space_left   = r_out_left;

endmodule

// ===== hdl/fpba_checker.sv =====
// Port-level checker of the allocator and its bind to the top level.
module fpba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_granted,
    input logic [3:0]  i_chosen_block,
    input logic [15:0] i_space_left
);

    // a held response stays valid
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // a held response keeps its payload
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_granted) && $stable(i_chosen_block) && $stable(i_space_left))
        else $error("response payload changed while stalled");

    // one request in flight: ready drops after each accepted request
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in work");

    // refused or load responses carry no block and no size
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_granted |-> (i_chosen_block == 4'd0) && (i_space_left == 16'd0))
        else $error("ungranted response with nonzero fields");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_granted      (o_rsp.granted),
    .i_chosen_block (o_rsp.chosen_block),
    .i_space_left   (o_rsp.space_left)
);

// ===== dv/fit_policy_block_allocator_tb.sv =====
// Self-checking testbench for the fit-policy block allocator: predictor, scoreboard, stimulus.
`timescale 1ns / 1ps

module fit_policy_block_allocator_tb;
    import fpba_pkg::*;

    localparam int BLOCKS       = DEF_NUM_BLOCKS;
    localparam int HOLD_CYCLES  = 200;  // long output hold-off, fills the block
    localparam int DRAIN_CYCLES = 24;   // longer than the worst allocation latency
    localparam int PHASES       = 11;
    localparam int PHASE_ITEMS  = 95;
    localparam int MAX_REPORTS  = 40;   // mismatch lines printed, all are counted

    // Policy code with no own meaning; it falls back to first fit
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic                     granted;
        logic [LOAD_IDX_BITS-1:0] block;
        logic [SIZE_VAL_BITS-1:0] left;
    } alloc_result_t;

    // Mirror of the size table and registers, plus the queue of responses
    // still owed by the block, oldest first.
    class alloc_scoreboard;
        logic [SIZE_VAL_BITS-1:0] remaining [BLOCKS];
        logic [MODE_BITS-1:0]     policy;
        logic [COUNT_BITS-1:0]    span;
        alloc_result_t            due [$];
        int errors, n_loads, n_grants, n_refusals, n_settings;

        function void clear();
            foreach (remaining[i]) remaining[i] = '0;
            policy = MODE_FIRST;
            span   = BLOCKS_RESET;
            due.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_FIT_MODE) policy = data[MODE_BITS-1:0];
            else if (idx == REG_BLOCKS_IN_USE) span = data[COUNT_BITS-1:0];
        endfunction

        // Called for each accepted request transaction
        function void note_request(logic op, logic [LOAD_IDX_BITS-1:0] idx,
                                   logic [SIZE_VAL_BITS-1:0] size);
            alloc_result_t r;
            int            limit;
            int            pick;
            bit            found;
            r = '0;
            if (op == OP_LOAD) begin
                remaining[idx] = size;
                n_loads++;
                due.push_back(r);
                return;
            end
            limit = (span > BLOCKS) ? BLOCKS : int'(span);
            found = 1'b0;
            pick  = 0;
            for (int j = 0; j < limit; j++) begin
                if (remaining[j] >= size) begin
                    if (!found) begin
                        found = 1'b1;
                        pick  = j;
                        if (policy != MODE_BEST && policy != MODE_WORST) break;
                    end else if (policy == MODE_BEST && remaining[j] < remaining[pick]) begin
                        pick = j;
                    end else if (policy == MODE_WORST && remaining[j] > remaining[pick]) begin
                        pick = j;
                    end
                end
            end
            if (found) begin
                remaining[pick] = remaining[pick] - size;
                r.granted = 1'b1;
                r.block   = LOAD_IDX_BITS'(pick);
                r.left    = remaining[pick];
                n_grants++;
            end else begin
                n_refusals++;
            end
            due.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
        endtask

        // Called for each accepted response transaction
        task check_response(alloc_result_t got);
            alloc_result_t want;
            if (due.size() == 0) begin
                report_mismatch($sformatf("unexpected response granted=%0d block=%0d left=%0d",
                                          got.granted, got.block, got.left));
                return;
            end
            want = due.pop_front();
            if (got.granted !== want.granted)
                report_mismatch($sformatf("granted %0d, want %0d", got.granted, want.granted));
            if (got.block !== want.block)
                report_mismatch($sformatf("chosen_block %0d, want %0d", got.block, want.block));
            if (got.left !== want.left)
                report_mismatch($sformatf("space_left %0d, want %0d", got.left, want.left));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    fpba_req_if req_ch ();
    fpba_rsp_if rsp_ch ();
    fpba_cfg_if cfg_ch ();

    fit_policy_block_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    alloc_scoreboard sb;

    int send_idle_pct;   // chance of a gap before each request, percent
    int take_idle_pct;   // chance of a response stall burst, percent
    bit hold_req;        // asks the response side for one long hold-off
    int n_holds;

    // Register settings of the random phases; upper data bits are set in
    // a few of them, the block must ignore those.
    logic [CFG_DATA_BITS-1:0] phase_mode [PHASES] = '{
        {6'd0, MODE_BEST}, {6'd0, MODE_WORST}, {6'd0, MODE_FIRST},
        {6'h3F, MODE_UNUSED}, {6'd0, MODE_BEST}, {6'd0, MODE_WORST},
        {6'd0, MODE_BEST}, {6'd0, MODE_WORST}, {6'h2A, MODE_BEST},
        {6'd0, MODE_UNUSED}, {6'd0, MODE_FIRST}
    };
    logic [CFG_DATA_BITS-1:0] phase_count [PHASES] = '{
        8'd16, 8'd16, 8'd7, 8'd16, 8'd1, 8'd0, 8'd31, 8'd17,
        {3'b111, 5'd12}, 8'd3, 8'd16
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Response side: ready changes at the falling edge. Random stall
    // bursts, plus one long hold-off on request.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                n_holds++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (take_idle_pct > 0 && $urandom_range(0, 99) < take_idle_pct) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Response monitor, samples at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response({rsp_ch.granted, rsp_ch.chosen_block, rsp_ch.space_left});
    end

    // Offer one request transaction, optionally after a random gap. Starts
    // and ends at a falling edge; valid stays high for a following item.
    task automatic send_item(logic op, logic [LOAD_IDX_BITS-1:0] idx,
                             logic [SIZE_VAL_BITS-1:0] size);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.load_index <= idx;
        req_ch.size_value <= size;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(op, idx, size);
        @(negedge i_clk);
    endtask

    // Drain: every owed response in, then let the last write-back settle
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Both registers, back to back, only with the block idle
    task automatic program_regs(logic [CFG_DATA_BITS-1:0] mode_val,
                                logic [CFG_DATA_BITS-1:0] count_val);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_FIT_MODE;
        cfg_ch.data  <= mode_val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.write_reg(REG_FIT_MODE, mode_val);
        @(negedge i_clk);
        cfg_ch.index <= REG_BLOCKS_IN_USE;
        cfg_ch.data  <= count_val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.write_reg(REG_BLOCKS_IN_USE, count_val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        sb.n_settings++;
    endtask

    // Random traffic. Most allocation requests are sized from what the table holds,
    // so grants, exact fits and ties stay common; the rest are zero,
    // full-range or tiny requests. Loads refill blocks, often with a few
    // repeated sizes so that best and worst fit see equal candidates.
    task automatic run_phase(int items, int hold_at);
        for (int n = 0; n < items; n++) begin
            logic                     op;
            logic [LOAD_IDX_BITS-1:0] idx;
            logic [SIZE_VAL_BITS-1:0] size;
            int                       sel;
            int                       j;
            idx = LOAD_IDX_BITS'($urandom_range(0, BLOCKS - 1));
            if ($urandom_range(0, 99) < 35) begin
                op  = OP_LOAD;
                sel = $urandom_range(0, 9);
                if (sel < 4) size = SIZE_VAL_BITS'($urandom);
                else if (sel < 7) size = SIZE_VAL_BITS'($urandom_range(1, 6) * 64);
                else if (sel < 9) size = SIZE_VAL_BITS'($urandom_range(0, 255));
                else size = $urandom_range(0, 1) ? '1 : '0;
            end else begin
                op  = OP_ALLOC;
                sel = $urandom_range(0, 19);
                j   = $urandom_range(0, BLOCKS - 1);
                if (sel < 2) size = '0;
                else if (sel < 4) size = SIZE_VAL_BITS'($urandom);
                else if (sel == 4) size = '1;
                else if (sel < 8) size = SIZE_VAL_BITS'($urandom_range(1, 255));
                else if (sb.remaining[j] == 0) size = SIZE_VAL_BITS'($urandom_range(0, 64));
                else if (sel == 8) size = sb.remaining[j];
                else size = SIZE_VAL_BITS'($urandom_range(1, sb.remaining[j]));
            end
            send_item(op, idx, size);
            if (n == hold_at) hold_req = 1'b1;
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        hold_req      = 1'b0;
        n_holds       = 0;
        send_idle_pct = 30;
        take_idle_pct = 30;

        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_LOAD;
        req_ch.load_index = '0;
        req_ch.size_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_FIT_MODE;
        cfg_ch.data       = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset settings (first fit over all blocks).
        // Table is all zeros: a zero request fits block 0 and keeps it at
        // zero, any other request is refused.
        send_item(OP_ALLOC, 4'd0, 16'd0);
        send_item(OP_ALLOC, 4'd7, 16'd1);
        send_item(OP_LOAD, 4'd0, 16'hFFFF);
        send_item(OP_LOAD, 4'd15, 16'hFFFF);
        send_item(OP_LOAD, 4'd5, 16'd100);
        send_item(OP_LOAD, 4'd6, 16'd100);
        send_item(OP_LOAD, 4'd10, 16'd300);
        send_item(OP_LOAD, 4'd1, 16'hAAAA);
        send_item(OP_LOAD, 4'd2, 16'h5555);
        send_item(OP_LOAD, 4'd14, 16'hFFFE);
        send_item(OP_ALLOC, 4'd15, 16'hFFFF);   // whole block, space_left 0
        send_item(OP_ALLOC, 4'd0, 16'd200);
        send_item(OP_ALLOC, 4'd3, 16'd0);
        // Best fit: two blocks of 100 tie, lowest index wins
        program_regs({6'd0, MODE_BEST}, 8'd16);
        send_item(OP_ALLOC, 4'd0, 16'd100);
        send_item(OP_ALLOC, 4'd0, 16'd2);
        send_item(OP_ALLOC, 4'd0, 16'hFFFF);
        // Worst fit: largest block, then a zero request, then a refused one
        program_regs({6'd0, MODE_WORST}, 8'd16);
        send_item(OP_ALLOC, 4'd0, 16'd1);
        send_item(OP_ALLOC, 4'd0, 16'd0);
        send_item(OP_ALLOC, 4'd0, 16'hFFFF);
        send_item(OP_LOAD, 4'd15, 16'd0);
        send_item(OP_LOAD, 4'd3, 16'd1);

        // Random phases. One long output hold-off in the second phase, no idling
        // in the third phase, and a quiet last phase.
        for (int p = 0; p < PHASES; p++) begin
            program_regs(phase_mode[p], phase_count[p]);
            if (p == 2 || p == PHASES - 1) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(0, 2) * 20;
                take_idle_pct = $urandom_range(0, 2) * 20;
            end
            run_phase(PHASE_ITEMS, (p == 1) ? 20 : -1);
        end

        wait_idle();
        while (sb.due.size() != 0) begin
            alloc_result_t lost;
            lost = sb.due.pop_front();
            sb.report_mismatch($sformatf("response never seen, granted=%0d block=%0d",
                                         lost.granted, lost.block));
        end

        $display("summary: %0d loads, %0d grants, %0d refusals over %0d register settings",
                 sb.n_loads, sb.n_grants, sb.n_refusals, sb.n_settings + 1);
        $display("summary: %0d long output hold-off(s), %0d mismatches",
                 n_holds, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("timeout: run did not complete, %0d responses outstanding", sb.due.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fpba_pkg.sv
hdl/fpba_ifs.sv
hdl/fpba_ctrl.sv
hdl/fpba_dp.sv
hdl/fit_policy_block_allocator.sv
hdl/fpba_checker.sv
dv/fit_policy_block_allocator_tb.sv
